FILE: rtl/core/ptsr_pkg.sv
// shared widths, register indexes and constants of the pitch pid step rate drive
package ptsr_pkg;

    localparam int PITCH_W    = 17;
    localparam int ERR_W      = PITCH_W + 1;
    localparam int GAIN_W     = 16;
    localparam int DT_W       = 16;
    localparam int INTEG_W    = 48;
    localparam int MUL_OP_W   = 48;
    localparam int MUL_P_W    = GAIN_W + MUL_OP_W;
    localparam int DIV_N_W    = ERR_W + 1 + DT_W;
    localparam int DIV_D_W    = 16;
    localparam int DER_W      = DIV_N_W + 1;
    localparam int SUM_W      = 56;
    localparam int FRAC_W     = 16;
    localparam int DRIVE_W    = 32;
    localparam int RATE_OUT_W = 9;
    localparam int PERIOD_W   = 29;
    localparam int PULSE_W    = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 104;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SECONDS = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd12800;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;
    localparam logic [DT_W-1:0]   DT_RST     = 16'd655;

    localparam int MAX_RATE_HZ_DEF = 300;

    localparam logic [DIV_N_W-1:0] PERIOD_NUM = 35'd1000000000;

endpackage

FILE: rtl/core/ptsr_mul.sv
// bit serial multiplier: unsigned gain times signed operand, one gain bit per cycle
module ptsr_mul (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [ptsr_pkg::GAIN_W-1:0]           gain,
    input  logic signed [ptsr_pkg::MUL_OP_W-1:0]  operand,
    output logic                                  busy,
    output logic signed [ptsr_pkg::MUL_P_W-1:0]   product
);
    import ptsr_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    logic                      busy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [MUL_P_W-1:0] op_reg;
    logic signed [MUL_P_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            gain_reg <= gain;
            op_reg   <= MUL_P_W'(operand);
            acc_reg  <= '0;
        end else if (busy_reg) begin
            if (gain_reg[0]) begin
                acc_reg <= acc_reg + op_reg;
            end
            op_reg   <= op_reg <<< 1;
            gain_reg <= gain_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/core/ptsr_div.sv
// restoring divider, one quotient bit per cycle
module ptsr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ptsr_pkg::DIV_N_W-1:0]  dividend,
    input  logic [ptsr_pkg::DIV_D_W-1:0]  divisor,
    output logic                          busy,
    output logic [ptsr_pkg::DIV_N_W-1:0]  quotient
);
    import ptsr_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   trial;

    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits the divisor width
            if (!trial[DIV_D_W+1]) begin
                rem_reg <= trial[DIV_D_W-1:0];
            end else begin
                rem_reg <= shifted[DIV_D_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_N_W-2:0], ~trial[DIV_D_W+1]};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/pid_to_step_rate_drive_top.sv
// pitch pid controller producing drive value, direction, step rate and pwm timing
//
//  port group  | dir | contents
//  ------------+-----+------------------------------------------------------------
//  s_*         | in  | one pitch sample per request
//  m_*         | out | drive, forward, step rate, pwm period, pwm pulse per request
//  cfg_*       | in  | register writes: target, three gains, tick period
//
// a sample is taken only once the previous one is in the output register; the
// work is set by the shared bit serial multiplier (four products) and the radix-2
// divider (the derivative, overlapped with two products, and the pwm period, left
// out when the drive is zero)
// reset is synchronous, clears integral and last error, resets cfg to defaults
// a finished result waits in the output register while the next sample is taken
module pid_to_step_rate_drive_top #(
    parameter int MAX_RATE_HZ = ptsr_pkg::MAX_RATE_HZ_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // [16:0] pitch_measured
    input  logic [ptsr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] drive_value, [32] forward, [41:33] step_rate_hz,
    // [70:42] pwm_period_ns, [98:71] pwm_pulse_ns
    output logic [ptsr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [ptsr_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ptsr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ptsr_pkg::*;

    localparam int RATE_W = $clog2(MAX_RATE_HZ + 1);
    localparam int DRV_Q_W = SUM_W - FRAC_W;
    localparam logic signed [DRV_Q_W-1:0] DRV_HI = DRV_Q_W'(64'sd2147483647);
    localparam logic signed [DRV_Q_W-1:0] DRV_LO = -DRV_HI;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic [FRAC_W-1:0] FRAC_ONES = '1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_M_DT  = 4'd2;
    localparam logic [3:0] S_M_KP  = 4'd3;
    localparam logic [3:0] S_W_DIV = 4'd4;
    localparam logic [3:0] S_M_KI  = 4'd5;
    localparam logic [3:0] S_M_KD  = 4'd6;
    localparam logic [3:0] S_DRIVE = 4'd7;
    localparam logic [3:0] S_RATE  = 4'd8;
    localparam logic [3:0] S_W_PER = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]                state_reg;
    logic signed [PITCH_W-1:0] target_reg;
    logic [GAIN_W-1:0]         kp_reg;
    logic [GAIN_W-1:0]         ki_reg;
    logic [GAIN_W-1:0]         kd_reg;
    logic [DT_W-1:0]           dt_reg;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic                      diff_neg_reg;
    logic signed [DER_W-1:0]   deriv_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [DRIVE_W-1:0]        drive_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic [PERIOD_W-1:0]       period_reg;

    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      m_tvalid_reg;

    logic                      mul_start;
    logic [GAIN_W-1:0]         mul_gain;
    logic signed [MUL_OP_W-1:0] mul_op;
    logic                      mul_busy;
    logic signed [MUL_P_W-1:0] mul_prod;

    logic                      div_start;
    logic [DIV_N_W-1:0]        div_num;
    logic [DIV_D_W-1:0]        div_den;
    logic                      div_busy;
    logic [DIV_N_W-1:0]        div_quo;

    logic signed [PITCH_W-1:0] pitch_in;
    logic signed [ERR_W-1:0]   err_calc;
    logic signed [ERR_W:0]     diff;
    logic [ERR_W:0]            diff_mag;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [DER_W-1:0]   quo_s;
    logic signed [DER_W-1:0]   deriv_calc;
    logic signed [MUL_P_W-1:0] ki_rnd;
    logic signed [INTEG_W-1:0] ki_term;
    logic signed [SUM_W-1:0]   sum_rnd;
    logic signed [DRV_Q_W-1:0] drive_q;
    logic [DRIVE_W-1:0]        drive_calc;
    logic [DRIVE_W-1:0]        mag;
    logic [RATE_W-1:0]         rate_calc;
    logic [DIV_D_W-1:0]        rate_ext;
    logic                      out_load;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            kp_reg     <= GAIN_P_RST;
            ki_reg     <= GAIN_I_RST;
            kd_reg     <= GAIN_D_RST;
            dt_reg     <= DT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PITCH_TARGET: target_reg <= $signed(cfg_wdata[PITCH_W-1:0]);
                CFG_GAIN_P:       kp_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:       ki_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:       kd_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_TICK_SECONDS: dt_reg     <= cfg_wdata[DT_W-1:0];
                default: ;
            endcase
        end
    end

    assign pitch_in = $signed(s_tdata[PITCH_W-1:0]);
    assign err_calc = ERR_W'(target_reg) - ERR_W'(pitch_in);
    assign diff     = (ERR_W+1)'(err_reg) - (ERR_W+1)'(last_err_reg);
    assign diff_mag = diff[ERR_W] ? (ERR_W+1)'(-diff) : diff;

    // integral update with saturation to the 48-bit range
    assign integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(mul_prod);
    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    // derivative sign restored after the magnitude division
    assign quo_s      = $signed({1'b0, div_quo});
    assign deriv_calc = (dt_reg == '0) ? '0 : (diff_neg_reg ? -quo_s : quo_s);

    // integral term scaled down, truncated toward zero
    assign ki_rnd  = mul_prod + (mul_prod[MUL_P_W-1] ? MUL_P_W'({1'b0, FRAC_ONES}) : '0);
    assign ki_term = $signed(ki_rnd[MUL_P_W-1:FRAC_W]);

    assign sum_rnd = sum_reg + (sum_reg[SUM_W-1] ? SUM_W'({1'b0, FRAC_ONES}) : '0);
    assign drive_q = $signed(sum_rnd[SUM_W-1:FRAC_W]);
    always_comb begin
        if (drive_q > DRV_HI) begin
            drive_calc = DRIVE_W'(DRV_HI);
        end else if (drive_q < DRV_LO) begin
            drive_calc = DRIVE_W'(DRV_LO);
        end else begin
            drive_calc = drive_q[DRIVE_W-1:0];
        end
    end

    assign mag = drive_reg[DRIVE_W-1] ? (DRIVE_W'(0) - drive_reg) : drive_reg;
    always_comb begin
        if (mag == '0) begin
            rate_calc = '0;
        end else if (mag >= DRIVE_W'(MAX_RATE_HZ)) begin
            rate_calc = RATE_W'(MAX_RATE_HZ);
        end else begin
            rate_calc = RATE_W'(mag + 1'b1);
        end
    end
    assign rate_ext = DIV_D_W'(rate_reg);

    // shared multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_gain  = dt_reg;
        mul_op    = MUL_OP_W'(err_reg);
        case (state_reg)
            S_START: begin
                mul_start = 1'b1;
            end
            S_M_DT: begin
                mul_start = !mul_busy;
                mul_gain  = kp_reg;
            end
            S_W_DIV: begin
                mul_start = !div_busy;
                mul_gain  = ki_reg;
                mul_op    = integ_reg;
            end
            S_M_KI: begin
                mul_start = !mul_busy;
                mul_gain  = kd_reg;
                mul_op    = MUL_OP_W'(deriv_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = {diff_mag, {DT_W{1'b0}}};
        div_den   = dt_reg;
        case (state_reg)
            S_START: begin
                div_start = (dt_reg != '0);
            end
            S_RATE: begin
                div_start = (rate_calc != '0);
                div_num   = PERIOD_NUM;
                div_den   = DIV_D_W'(rate_calc);
            end
            default: ;
        endcase
    end

    ptsr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .gain    (mul_gain),
        .operand (mul_op),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    ptsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // sequencer and state that survives between samples
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            integ_reg    <= '0;
            last_err_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    last_err_reg <= err_reg;
                    state_reg    <= S_M_DT;
                end
                S_M_DT: begin
                    if (!mul_busy) begin
                        integ_reg <= integ_sat;
                        state_reg <= S_M_KP;
                    end
                end
                S_M_KP: begin
                    if (!mul_busy) begin
                        state_reg <= S_W_DIV;
                    end
                end
                S_W_DIV: begin
                    if (!div_busy) begin
                        state_reg <= S_M_KI;
                    end
                end
                S_M_KI: begin
                    if (!mul_busy) begin
                        state_reg <= S_M_KD;
                    end
                end
                S_M_KD: begin
                    if (!mul_busy) begin
                        state_reg <= S_DRIVE;
                    end
                end
                S_DRIVE: begin
                    state_reg <= S_RATE;
                end
                S_RATE: begin
                    state_reg <= (rate_calc != '0) ? S_W_PER : S_OUT;
                end
                S_W_PER: begin
                    if (!div_busy) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // per-sample working registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            err_reg <= err_calc;
        end
        if (state_reg == S_START) begin
            diff_neg_reg <= diff[ERR_W];
        end
        if (state_reg == S_M_KP && !mul_busy) begin
            sum_reg <= mul_prod[SUM_W-1:0];
        end
        if (state_reg == S_W_DIV && !div_busy) begin
            deriv_reg <= deriv_calc;
        end
        if (state_reg == S_M_KI && !mul_busy) begin
            sum_reg <= sum_reg + SUM_W'(ki_term);
        end
        if (state_reg == S_M_KD && !mul_busy) begin
            sum_reg <= sum_reg + mul_prod[SUM_W-1:0];
        end
        if (state_reg == S_DRIVE) begin
            drive_reg <= drive_calc;
        end
        if (state_reg == S_RATE) begin
            rate_reg   <= rate_calc;
            period_reg <= '0;
        end
        if (state_reg == S_W_PER && !div_busy) begin
            period_reg <= div_quo[PERIOD_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {
                {(M_TDATA_W - DRIVE_W - 1 - RATE_OUT_W - PERIOD_W - PULSE_W){1'b0}},
                period_reg[PERIOD_W-1:1],
                period_reg,
                rate_ext[RATE_OUT_W-1:0],
                ~drive_reg[DRIVE_W-1],
                drive_reg
            };
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken while the previous one is still in work");

    a_mul_idle_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted before finishing");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (div_den != '0) && !div_busy)
        else $error("divider started with zero divisor or while busy");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result shown outside the output step");

endmodule

FILE: verif/pid_to_step_rate_drive_top_tb.sv
// self-checking bench for the pitch pid step rate drive: directed table, then random samples
`timescale 1ns / 100ps

module pid_to_step_rate_drive_top_tb;

    import ptsr_pkg::*;

    localparam int      MAX_RATE     = MAX_RATE_HZ_DEF;
    localparam int      LIMIT_CYCLES = 600000;
    localparam int      DRAIN_CYCLES = 150;
    localparam int      PHASES       = 10;
    localparam int      PHASE_ITEMS  = 70;
    localparam longint  INTEG_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint  INTEG_LO     = -INTEG_HI - 1;
    localparam longint  DRIVE_HI     = 64'sd2147483647;
    localparam longint  PERIOD_NUM_NS = 64'sd1000000000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {SET_EXTREME, SET_REALISTIC, SET_ANY, SET_DEFAULT_GAINS} setting_mode_t;

    typedef struct packed {
        logic [PULSE_W-1:0]    pwm_pulse_ns;
        logic [PERIOD_W-1:0]   pwm_period_ns;
        logic [RATE_OUT_W-1:0] step_rate_hz;
        logic                  forward;
        logic [DRIVE_W-1:0]    drive_value;
    } drive_result_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [16:0]           value;
        bit                    typed;
        drive_result_t         want;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // controller state as the block should hold it
    logic signed [16:0] target_reg;
    logic [15:0]        kp_reg, ki_reg, kd_reg, dt_reg;
    longint             integ_acc, last_err;

    drive_result_t expected_drive_q[$];
    plan_row_t     plan[$];
    drive_result_t got_result, want_result;

    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  samples_sent    = 0;
    int  settings_count  = 0;
    int  cycle_count     = 0;
    int  sink_hold       = 0;
    bit  burst_mode      = 1'b0;

    pid_to_step_rate_drive_top #(
        .MAX_RATE_HZ(MAX_RATE)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t timeout after %0d cycles, %0d results pending", $time, cycle_count,
                     expected_drive_q.size());
            $display("[pid_to_step_rate_drive_top] ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 5);
    endfunction

    // one control tick: error, saturating integral, derivative, pid sum, rate and pwm timing
    function automatic drive_result_t predict_drive(input logic [16:0] pitch_raw);
        longint pitch, err, dt, integ, deriv, sum, drive, mag, rate, period;
        drive_result_t r;
        pitch = longint'($signed(pitch_raw));
        err   = longint'(target_reg) - pitch;
        dt    = longint'(dt_reg);
        integ = integ_acc + err * dt;
        if (integ > INTEG_HI) integ = INTEG_HI;
        if (integ < INTEG_LO) integ = INTEG_LO;
        integ_acc = integ;
        deriv = (dt != 0) ? ((err - last_err) * 65536) / dt : 0;
        last_err = err;
        sum = longint'(kp_reg) * err + (longint'(ki_reg) * integ) / 65536
            + longint'(kd_reg) * deriv;
        drive = sum / 65536;
        if (drive > DRIVE_HI) drive = DRIVE_HI;
        if (drive < -DRIVE_HI) drive = -DRIVE_HI;
        mag    = (drive < 0) ? -drive : drive;
        rate   = 0;
        period = 0;
        if (mag != 0) begin
            rate = mag + 1;
            if (rate > MAX_RATE) rate = MAX_RATE;
            period = PERIOD_NUM_NS / rate;
        end
        r.drive_value   = drive[DRIVE_W-1:0];
        r.forward       = (drive >= 0);
        r.step_rate_hz  = rate[RATE_OUT_W-1:0];
        r.pwm_period_ns = period[PERIOD_W-1:0];
        r.pwm_pulse_ns  = PULSE_W'(period / 2);
        return r;
    endfunction

    function automatic drive_result_t result_of(input longint drive, input bit fwd,
                                                input longint rate, input longint period,
                                                input longint pulse);
        drive_result_t r;
        r.drive_value   = drive[DRIVE_W-1:0];
        r.forward       = fwd;
        r.step_rate_hz  = rate[RATE_OUT_W-1:0];
        r.pwm_period_ns = period[PERIOD_W-1:0];
        r.pwm_pulse_ns  = pulse[PULSE_W-1:0];
        return r;
    endfunction

    task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] value);
        plan_row_t row;
        row = '{is_write: 1'b1, reg_index: idx, value: value, typed: 1'b0, want: '0};
        plan.push_back(row);
    endtask

    task automatic plan_sample(input logic [16:0] pitch, input bit typed,
                               input drive_result_t want);
        plan_row_t row;
        row = '{is_write: 1'b0, reg_index: '0, value: pitch, typed: typed, want: want};
        plan.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_PITCH_TARGET: target_reg = value;
            CFG_GAIN_P:       kp_reg = value[15:0];
            CFG_GAIN_I:       ki_reg = value[15:0];
            CFG_GAIN_D:       kd_reg = value[15:0];
            CFG_TICK_SECONDS: dt_reg = value[15:0];
            default: ;
        endcase
    endtask

    // register writes only once every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_sample(input logic [16:0] pitch, input bit typed,
                               input drive_result_t want);
        int gap;
        drive_result_t predicted;
        gap = draw_gap();
        cfg_we <= 1'b0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'(pitch);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_drive(pitch);
        expected_drive_q.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    task automatic report_field(input string field, input longint want, input longint got);
        $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    // result side: once a result shows up, stall for a random gap from draw_gap, except in burst mode
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            sink_hold <= draw_gap();
            m_tready  <= burst_mode;
        end else if (m_tvalid) begin
            if (sink_hold == 0) m_tready <= 1'b1;
            else sink_hold <= sink_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = drive_result_t'(m_tdata[$bits(drive_result_t)-1:0]);
            if (expected_drive_q.size() == 0) begin
                $display("%0t unexpected result: drive %0d", $time,
                         $signed(got_result.drive_value));
                mismatch_count++;
            end else begin
                want_result = expected_drive_q.pop_front();
                results_checked++;
                if (want_result.drive_value !== got_result.drive_value)
                    report_field("drive_value", longint'($signed(want_result.drive_value)),
                                 longint'($signed(got_result.drive_value)));
                if (want_result.forward !== got_result.forward)
                    report_field("forward", want_result.forward, got_result.forward);
                if (want_result.step_rate_hz !== got_result.step_rate_hz)
                    report_field("step_rate_hz", want_result.step_rate_hz,
                                 got_result.step_rate_hz);
                if (want_result.pwm_period_ns !== got_result.pwm_period_ns)
                    report_field("pwm_period_ns", want_result.pwm_period_ns,
                                 got_result.pwm_period_ns);
                if (want_result.pwm_pulse_ns !== got_result.pwm_pulse_ns)
                    report_field("pwm_pulse_ns", want_result.pwm_pulse_ns,
                                 got_result.pwm_pulse_ns);
            end
        end
    end

    initial begin
        drive_result_t stopped, none, full_fwd, full_rev;
        setting_mode_t mode;
        int phase, n;
        logic [16:0] pitch;

        target_reg = '0;
        kp_reg     = GAIN_P_RST;
        ki_reg     = GAIN_I_RST;
        kd_reg     = GAIN_D_RST;
        dt_reg     = DT_RST;
        integ_acc  = 0;
        last_err   = 0;

        stopped  = result_of(0, 1'b1, 0, 0, 0);
        none     = '0;
        full_fwd = result_of(DRIVE_HI, 1'b1, MAX_RATE, 3333333, 1666666);
        full_rev = result_of(-DRIVE_HI, 1'b0, MAX_RATE, 3333333, 1666666);

        // zero error straight out of reset
        plan_sample(17'd0, 1'b1, stopped);
        plan_sample(17'd256, 1'b0, none);
        plan_sample(17'(-46080), 1'b0, none);
        plan_sample(17'(46080), 1'b0, none);
        plan_sample(17'h0FFFF, 1'b0, none);
        plan_sample(17'h10000, 1'b0, none);
        // all gains zero: the integral still moves but nothing reaches the sum
        plan_write(CFG_GAIN_P, 17'd0);
        plan_write(CFG_GAIN_I, 17'd0);
        plan_write(CFG_GAIN_D, 17'd0);
        plan_sample(17'h1ABCD, 1'b1, stopped);
        // widest error both ways at full proportional gain
        plan_write(CFG_GAIN_P, 17'h0FFFF);
        plan_write(CFG_PITCH_TARGET, 17'h0FFFF);
        plan_sample(17'h10000, 1'b1, result_of(131069, 1'b1, MAX_RATE, 3333333, 1666666));
        plan_write(CFG_PITCH_TARGET, 17'h10000);
        plan_sample(17'h0FFFF, 1'b1, result_of(-131069, 1'b0, MAX_RATE, 3333333, 1666666));
        // sum just below zero truncates to a stop, forward stays set
        plan_write(CFG_GAIN_P, 17'd1);
        plan_write(CFG_PITCH_TARGET, 17'd0);
        plan_sample(17'd1, 1'b1, stopped);
        // one drive unit: slowest rate, longest period
        plan_write(CFG_GAIN_P, 17'd256);
        plan_sample(17'd256, 1'b1, result_of(-1, 1'b0, 2, 500000000, 250000000));
        plan_sample(17'h1FF00, 1'b1, result_of(1, 1'b1, 2, 500000000, 250000000));
        // around the rate clamp
        plan_write(CFG_GAIN_P, 17'd512);
        plan_sample(17'(-38144), 1'b0, none);
        plan_sample(17'(-38272), 1'b0, none);
        plan_sample(17'(-38400), 1'b0, none);
        // full derivative gain at the shortest tick saturates the drive
        plan_write(CFG_GAIN_P, 17'd0);
        plan_write(CFG_GAIN_D, 17'h0FFFF);
        plan_write(CFG_TICK_SECONDS, 17'd1);
        plan_sample(17'h10000, 1'b0, none);
        plan_sample(17'h0FFFF, 1'b1, full_rev);
        plan_sample(17'h10000, 1'b1, full_fwd);
        // zero tick: no derivative and no integral growth
        plan_write(CFG_GAIN_P, 17'd256);
        plan_write(CFG_GAIN_I, 17'h0FFFF);
        plan_write(CFG_TICK_SECONDS, 17'd0);
        plan_sample(17'h00100, 1'b0, none);
        plan_sample(17'h1F000, 1'b0, none);
        // writes to unused indexes change nothing
        plan_write(CFG_TICK_SECONDS, 17'd655);
        plan_write(CFG_SPARE_LO, 17'h1FFFF);
        plan_write(CFG_SPARE_HI, 17'h00001);
        plan_sample(17'h00200, 1'b0, none);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                wait_drained();
                write_reg(plan[i].reg_index, plan[i].value);
            end else begin
                send_sample(plan[i].value, plan[i].typed, plan[i].want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            burst_mode = (phase % 4 == 3);
            mode = (phase < 2) ? SET_EXTREME : setting_mode_t'($urandom_range(0, 3));
            settings_count++;
            case (mode)
                SET_EXTREME: begin
                    // bit 16 set on a gain write must be dropped
                    write_reg(CFG_PITCH_TARGET, $urandom_range(0, 1) ? 17'(46080) : 17'(-46080));
                    write_reg(CFG_GAIN_P, $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000);
                    write_reg(CFG_GAIN_I, $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000);
                    write_reg(CFG_GAIN_D, $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000);
                    write_reg(CFG_TICK_SECONDS, $urandom_range(0, 1) ? 17'h1FFFF : 17'd1);
                end
                SET_REALISTIC: begin
                    write_reg(CFG_PITCH_TARGET, 17'(int'($urandom_range(0, 5120)) - 2560));
                    write_reg(CFG_GAIN_P, 17'($urandom_range(0, 4096)));
                    write_reg(CFG_GAIN_I, 17'($urandom_range(0, 1024)));
                    write_reg(CFG_GAIN_D, 17'($urandom_range(0, 512)));
                    write_reg(CFG_TICK_SECONDS, 17'($urandom_range(100, 2000)));
                end
                SET_ANY: begin
                    write_reg(CFG_PITCH_TARGET, 17'($urandom));
                    write_reg(CFG_GAIN_P, 17'($urandom));
                    write_reg(CFG_GAIN_I, 17'($urandom));
                    write_reg(CFG_GAIN_D, 17'($urandom));
                    write_reg(CFG_TICK_SECONDS, 17'($urandom));
                end
                default: begin
                    write_reg(CFG_SPARE_LO, 17'($urandom));
                    write_reg(CFG_PITCH_TARGET, 17'(int'($urandom_range(0, 5120)) - 2560));
                    write_reg(CFG_GAIN_P, 17'(GAIN_P_RST));
                    write_reg(CFG_GAIN_I, 17'(GAIN_I_RST));
                    write_reg(CFG_GAIN_D, 17'(GAIN_D_RST));
                    write_reg(CFG_TICK_SECONDS, 17'(DT_RST));
                    write_reg(CFG_SPARE_HI, 17'($urandom));
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // mostly near the target, about one sample in five anywhere in the range
                if ($urandom_range(0, 4) == 0)
                    pitch = 17'($urandom);
                else
                    pitch = 17'(int'(target_reg) + int'($urandom_range(0, 1024)) - 512);
                send_sample(pitch, 1'b0, none);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d pitch samples sent (%0d directed rows, %0d random register settings)",
                 samples_sent, plan.size(), settings_count);
        $display("%0d results compared, %0d mismatches, %0d cycles", results_checked,
                 mismatch_count, cycle_count);
        if (mismatch_count == 0 && expected_drive_q.size() == 0) begin
            $display("[pid_to_step_rate_drive_top] OK");
        end else begin
            $display("[pid_to_step_rate_drive_top] ERROR");
        end
        $finish;
    end

endmodule
